### rtl/core/ldf_pkg.sv
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared types, codes and character tables of the length-prefixed deframer.
// ----------------------------------------------------------------------------
package ldf_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HDR_LEN,
        PH_HDR_BODY,
        PH_SMALL_LEN,
        PH_LARGE_LEN,
        PH_PAYLOAD
    } t_phase;

    // Error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_HTTP = 2'd1;
    localparam logic [1:0] ERR_HDR  = 2'd2;

    // All-ones escape length of the 16-bit length field
    localparam logic [15:0] LEN_ESCAPE = 16'hFFFF;

    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       frame_last;
        logic [1:0] error_code;
    } t_result;

    // "GET "
    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h45;
            2'd2:    c = 8'h54;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    // "TCP" CR LF CR LF
    function automatic logic [7:0] conn_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h54;
            3'd1:    c = 8'h43;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h0D;
            3'd4:    c = 8'h0A;
            3'd5:    c = 8'h0D;
            3'd6:    c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/ldf_parser.sv
// ----------------------------------------------------------------------------
// ldf_parser
// Parser state and one-byte step logic: header check, length fields, payload.
// ----------------------------------------------------------------------------
module ldf_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output ldf_pkg::t_result o_res
);
    import ldf_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_rem, n_rem;
    logic        r_gmatch, n_gmatch;
    logic        r_dead, n_dead;
    logic        r_server, n_server;

    logic        go;
    logic        get_hit;
    logic        hdr_bad;
    logic [31:0] rem_dec;
    logic [31:0] byte_ext;
    logic [31:0] large_acc;
    logic [31:0] small_acc;
    logic [4:0]  lg_shift;
    logic [4:0]  sm_shift;

    assign go       = i_step && !r_dead;
    assign byte_ext = {24'd0, i_byte};
    assign rem_dec  = r_rem - 32'd1;
    // position capped at the top byte of each length field
    assign lg_shift  = {(r_pos > 3'd3) ? 2'd3 : r_pos[1:0], 3'd0};
    assign sm_shift  = {3'd0, (r_pos > 3'd1) ? 1'b1 : r_pos[0], 1'b0} << 2;
    assign large_acc = r_acc | (byte_ext << lg_shift);
    assign small_acc = {16'd0, r_acc[15:0]} | (byte_ext << sm_shift);

    // "GET " completes on the second header body byte
    assign get_hit = (r_pos == 3'd1) && r_gmatch && (i_byte == get_char(2'd3));
    assign hdr_bad = (r_pos == 3'd6) && ((r_acc != 32'd0) || (i_byte != conn_char(r_pos)));

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_gmatch = r_gmatch;
        n_dead   = r_dead;
        n_server = r_server;
        if (i_cfg_we) begin
            n_server = i_cfg_wdata;
            n_phase  = i_cfg_wdata ? PH_HDR_LEN : PH_SMALL_LEN;
            n_pos    = 3'd0;
            n_acc    = 32'd0;
            n_rem    = 32'd0;
            n_gmatch = 1'b1;
        end else if (go) begin
            case (r_phase)
                PH_HDR_LEN: begin
                    if (r_pos < 3'd2 && i_byte != get_char(r_pos[1:0])) begin
                        n_gmatch = 1'b0;
                    end
                    if (r_pos >= 3'd1) begin
                        n_phase = PH_HDR_BODY;
                        n_pos   = 3'd0;
                        n_acc   = 32'd0;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end
                PH_HDR_BODY: begin
                    if (r_pos < 3'd2 && i_byte != get_char({1'b1, r_pos[0]})) begin
                        n_gmatch = 1'b0;
                    end
                    if (i_byte != conn_char(r_pos)) begin
                        n_acc = 32'd1;
                    end
                    if (get_hit || hdr_bad) begin
                        n_dead = 1'b1;
                    end else if (r_pos >= 3'd6) begin
                        n_phase = PH_SMALL_LEN;
                        n_pos   = 3'd0;
                        n_acc   = 32'd0;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end
                PH_LARGE_LEN: begin
                    if (r_pos >= 3'd3) begin
                        n_pos = 3'd0;
                        n_acc = 32'd0;
                        if (large_acc != 32'd0) begin
                            n_rem   = large_acc;
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_pos = r_pos + 3'd1;
                        n_acc = large_acc;
                    end
                end
                PH_PAYLOAD: begin
                    n_rem = rem_dec;
                    if (rem_dec == 32'd0) begin
                        n_phase = PH_SMALL_LEN;
                        n_pos   = 3'd0;
                        n_acc   = 32'd0;
                    end
                end
                default: begin
                    n_phase = PH_SMALL_LEN;
                    if (r_pos >= 3'd1) begin
                        n_pos = 3'd0;
                        n_acc = 32'd0;
                        if (small_acc == 32'd0 || small_acc == {16'd0, LEN_ESCAPE}) begin
                            n_phase = PH_LARGE_LEN;
                        end else begin
                            n_rem   = small_acc;
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_pos = r_pos + 3'd1;
                        n_acc = small_acc;
                    end
                end
            endcase
        end
    end

    // result of this byte
    always_comb begin
        o_res = '0;
        if (go) begin
            case (r_phase)
                PH_HDR_BODY: begin
                    if (get_hit) begin
                        o_res.valid      = 1'b1;
                        o_res.error_code = ERR_HTTP;
                    end else if (hdr_bad) begin
                        o_res.valid      = 1'b1;
                        o_res.error_code = ERR_HDR;
                    end
                end
                PH_PAYLOAD: begin
                    o_res.valid        = 1'b1;
                    o_res.payload_byte = i_byte;
                    o_res.frame_last   = (rem_dec == 32'd0);
                    o_res.error_code   = ERR_NONE;
                end
                default: begin
                    o_res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SMALL_LEN;
            r_pos    <= 3'd0;
            r_acc    <= 32'd0;
            r_rem    <= 32'd0;
            r_gmatch <= 1'b1;
            r_dead   <= 1'b0;
            r_server <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_rem    <= n_rem;
            r_gmatch <= n_gmatch;
            r_dead   <= n_dead;
            r_server <= n_server;
        end
    end

endmodule

### rtl/core/ldf_out_reg.sv
// ----------------------------------------------------------------------------
// ldf_out_reg
// Result register on the output channel, held while the sink stalls.
// ----------------------------------------------------------------------------
module ldf_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ldf_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [7:0]       o_payload_byte,
    output logic             o_frame_last,
    output logic [1:0]       o_error_code
);
    import ldf_pkg::*;

    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_err;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = i_res.valid;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_res.payload_byte;
            r_last <= i_res.frame_last;
            r_err  <= i_res.error_code;
        end
    end

    assign o_valid        = r_valid;
    assign o_payload_byte = r_byte;
    assign o_frame_last   = r_last;
    assign o_error_code   = r_err;

endmodule

### rtl/core/length_prefixed_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_core
// Each accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle while the result sink does not stall.
// Reset: synchronous, active low; parser starts in the small-length phase,
// client mode, no clearing pass.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    // receive byte channel
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_last,
    output logic [1:0] o_error_code
);
    import ldf_pkg::*;

    // Input register: holds one beat until the parser can step on it.
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       in_accept;
    logic       advance;
    t_result    step_res;

    // Step whenever a byte waits and the result register is free or draining;
    // bytes that yield no result still step, so the stage never idles.
    assign advance    = r_in_valid && (!o_res_valid || !i_res_stall);
    assign o_rx_stall = r_in_valid && !advance;
    assign in_accept  = i_rx_valid && !o_rx_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Payload of the input register: load on accept only.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Parser: header check, length assembly, payload count.
    ldf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .o_res       (step_res)
    );

    // Result register: hold the beat while the sink stalls.
    ldf_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (advance),
        .i_res          (step_res),
        .i_stall        (i_res_stall),
        .o_valid        (o_res_valid),
        .o_payload_byte (o_payload_byte),
        .o_frame_last   (o_frame_last),
        .o_error_code   (o_error_code)
    );

endmodule

### verif/tb_length_prefixed_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_length_prefixed_frame_deframer_core
// Self-checking bench for the length-prefixed frame deframer. A byte stream of
// well-formed frames in both modes is pushed through the receive channel. The
// frames use 16-bit, escaped and 32-bit lengths, and some are cut short by
// register writes. A scoreboard works out every payload and error beat and
// compares each one with the result channel. Both channels idle and stall at
// random. The run ends with a fatal HTTP or header error and the dead state after it.
// ----------------------------------------------------------------------------
module tb_length_prefixed_frame_deframer_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ldf_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1150;
    // Leave headroom for bytes without a beat before touching the register
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;

    // "GET " and "TCP" CR LF CR LF
    localparam logic [7:0] HTTP_PREFIX [4] = '{8'h47, 8'h45, 8'h54, 8'h20};
    localparam logic [7:0] CONN_HEADER [7] = '{8'h54, 8'h43, 8'h50, 8'h0D,
                                              8'h0A, 8'h0D, 8'h0A};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] err;
    } t_out_beat;

    // ------------------------------------------------------------------
    // Scoreboard: carries its own copy of the parser state, turns every
    // accepted byte into the beat it should produce (if any) and checks
    // the result channel against that list in order.
    // ------------------------------------------------------------------
    class frame_scoreboard;
        bit          server_mode;
        t_phase      phase;
        logic [2:0]  pos;
        logic [31:0] len_acc;
        logic [31:0] remaining;
        bit          get_match;
        bit          dead;
        t_out_beat   expected_beats[$];
        int          mismatches;
        int          payload_beats;
        int          frames_done;
        int          error_beats;

        function new();
            server_mode   = 1'b0;
            dead          = 1'b0;
            mismatches    = 0;
            payload_beats = 0;
            frames_done   = 0;
            error_beats   = 0;
            restart();
        endfunction

        // Back to the first phase of the current mode; dead is kept
        function void restart();
            phase     = server_mode ? PH_HDR_LEN : PH_SMALL_LEN;
            pos       = 3'd0;
            len_acc   = 32'd0;
            remaining = 32'd0;
            get_match = 1'b1;
        endfunction

        function void set_mode(input bit m);
            server_mode = m;
            restart();
        endfunction

        function void kill(input logic [1:0] code);
            t_out_beat beat;
            dead      = 1'b1;
            beat.data = 8'h00;
            beat.last = 1'b0;
            beat.err  = code;
            expected_beats.push_back(beat);
        endfunction

        function void note_rx_byte(input logic [7:0] b);
            t_out_beat beat;
            if (dead)
                return;
            case (phase)
                PH_HDR_LEN: begin
                    if (pos < 2 && b != HTTP_PREFIX[pos])
                        get_match = 1'b0;
                    pos++;
                    if (pos >= 2) begin
                        phase   = PH_HDR_BODY;
                        pos     = 3'd0;
                        len_acc = 32'd0;
                    end
                end
                PH_HDR_BODY: begin
                    // the first two body bytes finish the "GET " test
                    if (pos < 2) begin
                        if (b != HTTP_PREFIX[pos + 2])
                            get_match = 1'b0;
                        if (pos == 1 && get_match) begin
                            kill(ERR_HTTP);
                            return;
                        end
                    end
                    // len_acc doubles as the header mismatch flag here
                    if (pos < 7 && b != CONN_HEADER[pos])
                        len_acc = 32'd1;
                    pos++;
                    if (pos >= 7) begin
                        if (len_acc != 0) begin
                            kill(ERR_HDR);
                            return;
                        end
                        phase   = PH_SMALL_LEN;
                        pos     = 3'd0;
                        len_acc = 32'd0;
                    end
                end
                PH_LARGE_LEN: begin
                    if (pos > 3)
                        pos = 3'd3;
                    len_acc |= {24'h0, b} << (8 * pos);
                    pos++;
                    if (pos >= 4) begin
                        pos = 3'd0;
                        // a zero 32-bit length is skipped
                        if (len_acc != 0) begin
                            remaining = len_acc;
                            phase     = PH_PAYLOAD;
                        end
                        len_acc = 32'd0;
                    end
                end
                PH_PAYLOAD: begin
                    remaining = remaining - 32'd1;
                    beat.data = b;
                    beat.last = (remaining == 0);
                    beat.err  = ERR_NONE;
                    if (beat.last) begin
                        phase   = PH_SMALL_LEN;
                        pos     = 3'd0;
                        len_acc = 32'd0;
                    end
                    expected_beats.push_back(beat);
                end
                default: begin
                    phase = PH_SMALL_LEN;
                    if (pos > 1)
                        pos = 3'd1;
                    len_acc = (len_acc & 32'h0000_FFFF) | ({24'h0, b} << (8 * pos));
                    pos++;
                    if (pos >= 2) begin
                        pos = 3'd0;
                        if (len_acc == 0 || len_acc == {16'h0, LEN_ESCAPE}) begin
                            phase = PH_LARGE_LEN;
                        end else begin
                            remaining = len_acc;
                            phase     = PH_PAYLOAD;
                        end
                        len_acc = 32'd0;
                    end
                end
            endcase
        endfunction

        function void check_beat(input logic [7:0] data, input logic last,
                                 input logic [1:0] err);
            t_out_beat want;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result beat: byte %02h last %0b error %0d",
                             $time, data, last, err);
                return;
            end
            want = expected_beats.pop_front();
            if (want.data !== data || want.last !== last || want.err !== err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch: want %02h/%0b/%0d got %02h/%0b/%0d",
                             $time, want.data, want.last, want.err, data, last, err);
            end
            if (want.err != ERR_NONE) begin
                error_beats++;
            end else begin
                payload_beats++;
                if (want.last)
                    frames_done++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals and block
    // ------------------------------------------------------------------
    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_wdata;
    logic       i_rx_valid;
    logic       o_rx_stall;
    logic [7:0] i_rx_byte;
    logic       o_res_valid;
    logic       i_res_stall;
    logic [7:0] o_payload_byte;
    logic       o_frame_last;
    logic [1:0] o_error_code;

    frame_scoreboard sb;
    logic [7:0]      tx_stream[$];
    int unsigned     bytes_sent    = 0;
    int              tx_burst_left = 0;
    bit              no_gaps       = 1'b0;
    bit              hold_req      = 1'b0;
    int              cycle_count   = 0;

    length_prefixed_frame_deframer_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_payload_byte (o_payload_byte),
        .o_frame_last   (o_frame_last),
        .o_error_code   (o_error_code)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Hard stop in case a beat never turns up or the input never frees
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, sb.expected_beats.size());
            $display("tb_length_prefixed_frame_deframer_core: FAIL");
            $finish;
        end
    end

    // Watch both channels on the edge; note the input beat before the
    // result so that ordering inside the scoreboard never depends on it
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_rx_valid && o_rx_stall === 1'b0)
                sb.note_rx_byte(i_rx_byte);
            if (o_res_valid === 1'b1 && !i_res_stall)
                sb.check_beat(o_payload_byte, o_frame_last, o_error_code);
        end
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Mostly none or short, now and then a long one
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Lean on the extremes a little more than plain random would
    function automatic logic [7:0] rand_data();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void put_le16(input logic [15:0] v);
        tx_stream.push_back(v[7:0]);
        tx_stream.push_back(v[15:8]);
    endfunction

    function automatic void put_le32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            tx_stream.push_back(v[8 * i +: 8]);
    endfunction

    function automatic void put_payload(input int unsigned n);
        repeat (n) tx_stream.push_back(rand_data());
    endfunction

    // First n bytes of the connection header body; the caller adds the length
    function automatic void put_header_body(input int n);
        for (int i = 0; i < n; i++)
            tx_stream.push_back(CONN_HEADER[i]);
    endfunction

    // form 0: plain 16-bit length, 1: zero escape, 2: all-ones escape,
    // else: either escape with one or two skipped 32-bit zeros first
    function automatic void queue_frame(input logic [31:0] len, input int form);
        case (form)
            0: put_le16(len[15:0]);
            1: begin
                put_le16(16'h0000);
                put_le32(len);
            end
            2: begin
                put_le16(LEN_ESCAPE);
                put_le32(len);
            end
            default: begin
                put_le16($urandom_range(0, 1) ? LEN_ESCAPE : 16'h0000);
                repeat ($urandom_range(1, 2)) put_le32(32'd0);
                put_le32(len);
            end
        endcase
        put_payload(len);
    endfunction

    // Offer one beat and hold it until the block takes it. Valid is left
    // high so that a following beat can go straight out on the next edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!no_gaps) begin
            if (tx_burst_left > 0)
                tx_burst_left--;
            else if ($urandom_range(0, 39) == 0)
                tx_burst_left = $urandom_range(20, 120);
            else
                gap = gap_length();
        end
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall !== 1'b0);
        bytes_sent++;
    endtask

    task automatic send_stream();
        while (tx_stream.size() > 0)
            send_byte(tx_stream.pop_front());
    endtask

    // Drop valid, let every expected beat come out, then give the parser
    // time to finish any byte that produces no beat
    task automatic wait_idle();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input bit m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_mode(m);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls with calm stretches, plus one long
    // hold-off on request so that the block backs up into its input
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left  = 0;
        i_res_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    i_res_stall <= 1'b1;
                    @(posedge i_clk);
                end
                hold_req = 1'b0;
                i_res_stall <= 1'b0;
            end else if (stall_left > 0) begin
                i_res_stall <= 1'b1;
                stall_left--;
            end else begin
                i_res_stall <= 1'b0;
                if (free_left > 0)
                    free_left--;
                else if ($urandom_range(0, 49) == 0)
                    free_left = $urandom_range(30, 150);
                else if ($urandom_range(0, 3) == 0)
                    stall_left = gap_length();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        bit          mode;
        int unsigned rand_start;
        int          pick;
        int unsigned flen;
        int          k;

        sb = new();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_rx_valid  <= 1'b0;
        i_rx_byte   <= 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- Directed part --------------------------------------------
        // Client mode out of reset: two-byte frame at the data extremes
        put_le16(16'd2);
        tx_stream.push_back(8'h00);
        tx_stream.push_back(8'hFF);
        // Zero escape, a skipped 32-bit zero, then the real 32-bit length
        put_le16(16'h0000);
        put_le32(32'd0);
        put_le32(32'd1);
        tx_stream.push_back(8'h80);
        // All-ones escape straight into a 32-bit length
        put_le16(LEN_ESCAPE);
        put_le32(32'd1);
        tx_stream.push_back(8'h7F);
        send_stream();
        wait_idle();

        // Server mode: length bytes spell "GE" and the body's 'T' carries
        // on towards "GET", then 'C' breaks it; the header is good
        set_mode(1'b1);
        tx_stream.push_back(HTTP_PREFIX[0]);
        tx_stream.push_back(HTTP_PREFIX[1]);
        put_header_body(7);
        put_le16(16'd1);
        tx_stream.push_back(8'h5A);
        send_stream();

        // Long hold-off on the result side while a big frame goes in
        // gap-free, so the block fills up and stalls its input
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        queue_frame(32'd150, 0);
        send_stream();
        no_gaps = 1'b0;
        // Pause the sender until every beat is out
        wait_idle();

        // --- Random part ----------------------------------------------
        // Sessions: pick a mode (restarting the parser), send the header
        // if needed, a run of frames, and now and then a broken tail that
        // the next register write has to clear away
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RANDOM_ITEMS) begin
            wait_idle();
            mode = $urandom_range(0, 1);
            set_mode(mode);
            if (mode) begin
                if ($urandom_range(0, 5) == 0) begin
                    tx_stream.push_back(HTTP_PREFIX[0]);
                    tx_stream.push_back(HTTP_PREFIX[1]);
                end else begin
                    tx_stream.push_back(rand_data());
                    tx_stream.push_back(rand_data());
                end
                // Abandon the header half-way now and then
                if ($urandom_range(0, 6) == 0) begin
                    put_header_body($urandom_range(0, 6));
                    send_stream();
                    continue;
                end
                put_header_body(7);
            end
            repeat ($urandom_range(2, 10)) begin
                pick = $urandom_range(0, 99);
                if (pick < 74)
                    flen = $urandom_range(1, 8);
                else if (pick < 96)
                    flen = $urandom_range(9, 40);
                else
                    flen = $urandom_range(41, 300);
                queue_frame(flen, ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3));
            end
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        // huge 32-bit length, only the start of its payload
                        put_le16($urandom_range(0, 1) ? LEN_ESCAPE : 16'h0000);
                        put_le32($urandom | 32'h8000_0000);
                        put_payload($urandom_range(0, 12));
                    end
                    1: begin
                        put_le16(16'($urandom_range(32'h8000, 32'hFFFE)));
                        put_payload($urandom_range(0, 12));
                    end
                    2: begin
                        // cut inside a 32-bit length
                        put_le16(16'h0000);
                        repeat ($urandom_range(1, 3)) tx_stream.push_back(rand_data());
                    end
                    default: tx_stream.push_back(rand_data());
                endcase
            end
            send_stream();
            if ($urandom_range(0, 4) == 0)
                wait_idle();
        end

        // --- Fatal errors and the dead state --------------------------
        // Break the "GET " match, then restart: the write must re-arm it
        wait_idle();
        set_mode(1'b1);
        tx_stream.push_back(HTTP_PREFIX[0]);
        tx_stream.push_back(8'h51);
        send_stream();
        wait_idle();
        set_mode(1'b1);
        // Only one fatal error fits in a run; let the seed pick which
        if ($urandom_range(0, 1)) begin
            for (k = 0; k < 4; k++)
                tx_stream.push_back(HTTP_PREFIX[k]);
        end else begin
            tx_stream.push_back(rand_data());
            tx_stream.push_back(rand_data());
            put_header_body(7);
            k = $urandom_range(0, 6);
            tx_stream[2 + k] = tx_stream[2 + k] ^ 8'($urandom_range(1, 255));
        end
        // Everything after the error must be swallowed
        put_payload(30);
        send_stream();
        wait_idle();
        // A register write restarts the parser but does not revive it
        set_mode(1'b0);
        queue_frame(32'd3, 0);
        queue_frame(32'd2, 1);
        send_stream();
        wait_idle();

        $display("run covered %0d received bytes, %0d payload beats in %0d frames",
                 bytes_sent, sb.payload_beats, sb.frames_done);
        $display("%0d error beat(s); both modes, escaped lengths, restarts, long hold-off",
                 sb.error_beats);
        if (sb.mismatches == 0) begin
            $display("tb_length_prefixed_frame_deframer_core: PASS");
        end else begin
            $display("%0d result beat(s) wrong or unexpected", sb.mismatches);
            $display("tb_length_prefixed_frame_deframer_core: FAIL");
        end
        $finish;
    end

endmodule
